FILE: rtl/external_interrupt_edge_controller_defines.svh
`ifndef EXTERNAL_INTERRUPT_EDGE_CONTROLLER_DEFINES_SVH
`define EXTERNAL_INTERRUPT_EDGE_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define EIEC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("eiec check failed");

// next-cycle implication, checked on clk, off during reset
`define EIEC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("eiec check failed");

`endif

FILE: rtl/eiec_pkg.sv
`timescale 1ns / 1ps

package eiec_pkg;

	localparam int unsigned LineCount = 16;
	localparam int unsigned DataW     = 32;
	localparam int unsigned PselWords = 4;

	typedef enum logic [1:0] {
		REQ_EVENT = 2'd0,
		REQ_READ  = 2'd1,
		REQ_WRITE = 2'd2,
		REQ_NONE  = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		EDGE_NONE    = 2'd0,
		EDGE_RISE    = 2'd1,
		EDGE_FALL    = 2'd2,
		EDGE_UNUSED  = 2'd3
	} edge_kind_t;

	localparam logic [5:0] REG_RISE_EN   = 6'd0;
	localparam logic [5:0] REG_FALL_EN   = 6'd1;
	localparam logic [5:0] REG_SW_TRIG   = 6'd2;
	localparam logic [5:0] REG_RISE_PEND = 6'd3;
	localparam logic [5:0] REG_FALL_PEND = 6'd4;
	localparam logic [5:0] REG_PSEL0     = 6'd24;
	localparam logic [5:0] REG_PSEL3     = 6'd27;

	typedef struct packed {
		req_kind_t          kind;
		logic [5:0]         reg_index;
		logic [DataW-1:0]   write_data;
		logic [7:0]         event_source;
		edge_kind_t         edge_kind;
	} req_t;

	typedef struct packed {
		logic [DataW-1:0]     read_data;
		logic [LineCount-1:0] irq_pulses;
		logic                 bad_address;
	} rsp_t;

endpackage

FILE: rtl/eiec_core.sv
`timescale 1ns / 1ps

module eiec_core import eiec_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  req_t req,
	output rsp_t rsp
);

	logic [LineCount-1:0]       rise_en_q;
	logic [LineCount-1:0]       fall_en_q;
	logic [LineCount-1:0]       rise_pend_q;
	logic [LineCount-1:0]       fall_pend_q;
	logic [DataW-1:0]           psel_q [PselWords];

	logic [LineCount-1:0]       rise_en_d;
	logic [LineCount-1:0]       fall_en_d;
	logic [LineCount-1:0]       rise_pend_d;
	logic [LineCount-1:0]       fall_pend_d;
	logic                       psel_we;

	logic [3:0]                 line;
	logic [3:0]                 port;
	logic [1:0]                 psel_addr;
	logic [DataW-1:0]           psel_word;
	logic [3:0]                 field;
	logic [LineCount-1:0]       line_bit;
	logic [LineCount-1:0]       wr_lo;
	logic                       is_psel;

	assign line      = req.event_source[3:0];
	assign port      = req.event_source[7:4];
	assign psel_addr = (req.kind == REQ_EVENT) ? line[3:2] : req.reg_index[1:0];
	assign psel_word = psel_q[psel_addr];
	assign field     = psel_word[{line[1:0], 3'b000} +: 4];
	assign line_bit  = LineCount'(1) << line;
	assign wr_lo     = req.write_data[LineCount-1:0];
	assign is_psel   = (req.reg_index >= REG_PSEL0) && (req.reg_index <= REG_PSEL3);

	always_comb begin
		rise_en_d   = rise_en_q;
		fall_en_d   = fall_en_q;
		rise_pend_d = rise_pend_q;
		fall_pend_d = fall_pend_q;
		psel_we     = 1'b0;
		rsp         = '0;
		case (req.kind)
			REQ_EVENT: begin
				if (field == port) begin
					if (req.edge_kind == EDGE_RISE && (rise_en_q & line_bit) != '0) begin
						rsp.irq_pulses = line_bit;
						rise_pend_d    = rise_pend_q | line_bit;
					end else if (req.edge_kind == EDGE_FALL &&
						(fall_en_q & line_bit) != '0) begin
						rsp.irq_pulses = line_bit;
						fall_pend_d    = fall_pend_q | line_bit;
					end
				end
			end
			REQ_READ: begin
				if (req.reg_index == REG_RISE_EN)
					rsp.read_data = DataW'(rise_en_q);
				else if (req.reg_index == REG_FALL_EN)
					rsp.read_data = DataW'(fall_en_q);
				else if (req.reg_index == REG_RISE_PEND)
					rsp.read_data = DataW'(rise_pend_q);
				else if (req.reg_index == REG_FALL_PEND)
					rsp.read_data = DataW'(fall_pend_q);
				else if (is_psel)
					rsp.read_data = psel_word;
				else
					rsp.bad_address = 1'b1;
			end
			REQ_WRITE: begin
				if (req.reg_index == REG_RISE_EN)
					rise_en_d = wr_lo;
				else if (req.reg_index == REG_FALL_EN)
					fall_en_d = wr_lo;
				else if (req.reg_index == REG_SW_TRIG) begin
					rise_pend_d    = rise_pend_q | wr_lo;
					rsp.irq_pulses = wr_lo;
				end else if (req.reg_index == REG_RISE_PEND)
					rise_pend_d = rise_pend_q & ~wr_lo;
				else if (req.reg_index == REG_FALL_PEND)
					fall_pend_d = fall_pend_q & ~wr_lo;
				else if (is_psel)
					psel_we = 1'b1;
				else
					rsp.bad_address = 1'b1;
			end
			default: begin
				rsp = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_en_q   <= '0;
			fall_en_q   <= '0;
			rise_pend_q <= '0;
			fall_pend_q <= '0;
			for (int i = 0; i < PselWords; i++) psel_q[2'(i)] <= '0;
		end else if (fire) begin
			rise_en_q   <= rise_en_d;
			fall_en_q   <= fall_en_d;
			rise_pend_q <= rise_pend_d;
			fall_pend_q <= fall_pend_d;
			if (psel_we) psel_q[psel_addr] <= req.write_data;
		end
	end

endmodule

FILE: rtl/external_interrupt_edge_controller.sv
`timescale 1ns / 1ps
// 16-line external interrupt controller.
// Request channel (req_valid / req_stall): one item per transfer, either a pin
// edge event (event_source, edge_kind) or a 32-bit register read or write
// (reg_index, write_data), chosen by req_type.
// Response channel (rsp_valid / rsp_stall): exactly one transfer per request,
// in order, carrying read_data, irq_pulses and bad_address.
// Order: a request transfer loads the request register, and an advance then moves
// it into the response register, which drives rsp_valid; a stall on the response
// register can hold the item in the request register in between.
// Throughput: one request per cycle unless rsp_stall holds a valid response; the
// register file is read and updated in the single cycle that moves an item from
// request to response register, so the next item always sees the updated state.
// Stall: while rsp_stall holds a valid response, the request register keeps
// its item and req_stall rises once it is full; nothing is dropped.
// Reset: all enables, pending bits and port selects clear to zero and both
// pipeline stages empty; req_stall is then low, so the block takes requests at once.

`include "external_interrupt_edge_controller_defines.svh"

module external_interrupt_edge_controller import eiec_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [1:0]           req_type,
	input  logic [5:0]           reg_index,
	input  logic [DataW-1:0]     write_data,
	input  logic [7:0]           event_source,
	input  logic [1:0]           edge_kind,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [DataW-1:0]     read_data,
	output logic [LineCount-1:0] irq_pulses,
	output logic                 bad_address
);

	logic valid_s1;
	req_t req_s1;
	logic valid_s2;
	rsp_t rsp_s2;
	rsp_t rsp_d;
	logic advance;

	assign advance   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1.kind         <= req_kind_t'(req_type);
			req_s1.reg_index    <= reg_index;
			req_s1.write_data   <= write_data;
			req_s1.event_source <= event_source;
			req_s1.edge_kind    <= edge_kind_t'(edge_kind);
		end
	end

	eiec_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.req    (req_s1),
		.rsp    (rsp_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !rsp_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) rsp_s2 <= rsp_d;
	end

	assign rsp_valid   = valid_s2;
	assign read_data   = rsp_s2.read_data;
	assign irq_pulses  = rsp_s2.irq_pulses;
	assign bad_address = rsp_s2.bad_address;

	`EIEC_ASSERT_NOW(a_bad_is_quiet, rsp_valid && bad_address, read_data == '0 && irq_pulses == '0)
	`EIEC_ASSERT_NOW(a_stall_only_when_full, req_stall, valid_s1 && rsp_valid && rsp_stall)
	`EIEC_ASSERT_NEXT(a_advance_gives_rsp, advance, rsp_valid)

endmodule
